>>> hdl/ssd_pkg.sv
// Shared types and constants for the shape signed distance pipeline.
// No dependencies.
package ssd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW = 40;
  localparam int SHW = $clog2(VW - 30);

  localparam logic [2:0] SH_SQUARE = 3'd0;
  localparam logic [2:0] SH_TRI    = 3'd1;
  localparam logic [2:0] SH_PENT   = 3'd2;
  localparam logic [2:0] SH_STAR   = 3'd3;
  localparam logic [2:0] SH_SPHERE = 3'd4;
  localparam logic [2:0] SH_CUBE   = 3'd5;

  typedef logic signed [VW-1:0] val_t;

  typedef enum logic [1:0] {
    SG_ZERO = 2'd0,
    SG_POS  = 2'd1,
    SG_NEG  = 2'd2
  } sgn_t;

  typedef struct packed {
    logic [2:0] shape;
    val_t r;
    val_t px;
    val_t py;
    val_t pz;
    val_t t0;
    val_t t1;
    val_t t2;
    val_t t3;
    val_t t4;
  } ctx_t;

  typedef struct packed {
    val_t la;
    val_t lb;
    val_t lc;
    val_t add;
    sgn_t sg;
  } lreq_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] root;
    logic [SHW-1:0] sh;
    val_t add;
    sgn_t sg;
  } sq_t;

endpackage

>>> hdl/shape_signed_distance.sv
// Pipeline of 36 register stages.
// Throughput: one beat per cycle; the whole pipeline holds while the output waits.
// Most of the depth comes from the shape folds (14 stages) and the 2-bit-per-stage root (16).
// Reset clears all valid bits; payload registers are not reset.
// Depends on ssd_pkg, ssd_prep, ssd_len, ssd_sqrt.
module shape_signed_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         shape,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [30:0]        size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] distance,
  output logic               saturated
);

  localparam int VW = ssd_pkg::VW;
  localparam int DW = VW + 2;
  localparam logic signed [DW-1:0] DMAX = DW'(32'sh7fffffff);
  localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);

  logic en;
  ssd_pkg::lreq_t lreq;
  logic lreq_vld;
  ssd_pkg::sq_t sq, rt;
  logic sq_vld, rt_vld;

  logic [VW:0] sc_len;
  ssd_pkg::val_t sc_add;
  ssd_pkg::sgn_t sc_sg;
  logic sc_vld;

  logic signed [DW-1:0] dsum;
  logic signed [31:0] distance_next;
  logic saturated_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  ssd_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid && in_ready),
    .shape(shape), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .size(size), .lreq(lreq), .lreq_vld(lreq_vld)
  );

  ssd_len u_len (
    .clk(clk), .rst(rst), .en(en), .lreq_vld(lreq_vld), .lreq(lreq),
    .sq_vld(sq_vld), .sq(sq)
  );

  ssd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .sq_vld(sq_vld), .sq(sq),
    .rt_vld(rt_vld), .rt(rt)
  );

  always_comb begin
    logic signed [DW-1:0] lens;
    lens = $signed({1'b0, sc_len});
    case (sc_sg)
      ssd_pkg::SG_POS: dsum = DW'(sc_add) + lens;
      ssd_pkg::SG_NEG: dsum = DW'(sc_add) - lens;
      default:         dsum = DW'(sc_add);
    endcase
    saturated_next = 1'b1;
    if (dsum > DMAX) begin
      distance_next = 32'sh7fffffff;
    end else if (dsum < DMIN) begin
      distance_next = 32'sh80000000;
    end else begin
      distance_next = dsum[31:0];
      saturated_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sc_vld <= rt_vld;
      out_valid <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_len <= (VW+1)'(rt.root[31:0]) << rt.sh;
      sc_add <= rt.add;
      sc_sg <= rt.sg;
      distance <= distance_next;
      saturated <= saturated_next;
    end
  end

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> distance == 32'sh7fffffff || distance == 32'sh80000000)
    else $error("saturated flag without clipped distance");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_scale_to_out: assert property (@(posedge clk) disable iff (rst)
    sc_vld && en |=> out_valid)
    else $error("result lost between scale and output stage");

endmodule

>>> hdl/ssd_prep.sv
// Shape front end: folds, projections and clamps, one multiply layer per stage.
// Produces the length request. Depends on ssd_pkg.
module ssd_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2:0]          shape,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic [30:0]         size,
  output ssd_pkg::lreq_t      lreq,
  output logic                lreq_vld
);

  typedef ssd_pkg::val_t val_t;
  typedef ssd_pkg::ctx_t ctx_t;
  localparam int VW = ssd_pkg::VW;
  localparam int KB = 24;
  localparam int PW = VW + KB + 1;
  localparam int NST = 13;
  typedef logic [KB:0] coef_t;

  localparam coef_t K_HALF       = 25'd8388608;
  localparam coef_t K_SQRT3      = 25'd29058991;
  localparam coef_t K_SQRT3_HALF = 25'd14529495;
  localparam coef_t K_PX         = 25'd13573053;
  localparam coef_t K_PY         = 25'd9861400;
  localparam coef_t K_PX2        = 25'd27146106;
  localparam coef_t K_PY2        = 25'd19722800;
  localparam coef_t K_PZ         = 25'd12189361;
  localparam coef_t K_BAX        = 25'd4930700;
  localparam coef_t K_NBAY       = 25'd9990690;
  localparam coef_t K_HX         = 25'd11181157;
  localparam coef_t K_NHY        = 25'd22655498;
  localparam val_t STAR_OFS =
    val_t'(((64'd1 << ssd_pkg::FRAC_BITS) + 64'd5) / 64'd10);

  // rounds half away from zero
  function automatic val_t mulk(val_t v, coef_t k);
    logic [VW-1:0] m;
    logic [PW-1:0] p;
    m = v[VW-1] ? VW'(-v) : VW'(v);
    p = PW'(m) * PW'(k) + (PW'(1) << (KB - 1));
    p = p >> KB;
    return v[VW-1] ? -val_t'(p[VW-1:0]) : val_t'(p[VW-1:0]);
  endfunction

  function automatic val_t vabs(val_t v);
    return v[VW-1] ? -v : v;
  endfunction

  function automatic val_t vmax(val_t a, val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic val_t vmin(val_t a, val_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic val_t vclamp(val_t v, val_t lo, val_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic ssd_pkg::sgn_t sgn_of(val_t v, logic flip);
    ssd_pkg::sgn_t s;
    if (v == val_t'(0)) s = ssd_pkg::SG_ZERO;
    else if ((v > val_t'(0)) ^ flip) s = ssd_pkg::SG_POS;
    else s = ssd_pkg::SG_NEG;
    return s;
  endfunction

  function automatic ctx_t step(int g, ctx_t c);
    ctx_t n;
    n = c;
    case (g)
      1, 5: begin
        if (c.shape == ssd_pkg::SH_PENT || c.shape == ssd_pkg::SH_STAR) begin
          n.t0 = mulk(c.px, K_PX);
          n.t1 = mulk(c.py, K_PY);
        end else if (g == 1 && c.shape == ssd_pkg::SH_TRI) begin
          n.t0 = mulk(c.py, K_SQRT3);
          n.t1 = mulk(c.px, K_HALF);
          n.t2 = mulk(c.py, K_SQRT3_HALF);
          n.t3 = mulk(c.px, K_SQRT3_HALF);
          n.t4 = mulk(c.py, K_HALF);
        end
      end
      2, 6: begin
        if (c.shape == ssd_pkg::SH_PENT) begin
          n.t2 = (g == 2) ? vmin(c.t1 - c.t0, '0) : vmin(c.t0 + c.t1, '0);
        end else if (c.shape == ssd_pkg::SH_STAR) begin
          n.t2 = (g == 2) ? vmax(c.t0 - c.t1, '0) : vmax(-c.t0 - c.t1, '0);
        end else if (g == 2 && c.shape == ssd_pkg::SH_TRI) begin
          if (c.px + c.t0 > val_t'(0)) begin
            n.px = c.t1 - c.t2;
            n.py = -c.t3 - c.t4;
          end
        end
      end
      3, 7: begin
        if (c.shape == ssd_pkg::SH_PENT || c.shape == ssd_pkg::SH_STAR) begin
          n.t0 = mulk(c.t2, K_PX2);
          n.t1 = mulk(c.t2, K_PY2);
        end else if (g == 3 && c.shape == ssd_pkg::SH_TRI) begin
          n.px = c.px - vclamp(c.px, -(c.r <<< 1), '0);
        end
      end
      4: begin
        if (c.shape == ssd_pkg::SH_PENT) begin
          n.px = c.px + c.t0;
          n.py = c.py - c.t1;
        end else if (c.shape == ssd_pkg::SH_STAR) begin
          n.px = c.px - c.t0;
          n.py = c.py + c.t1;
        end
      end
      8: begin
        if (c.shape == ssd_pkg::SH_PENT) begin
          n.px = c.px - c.t0;
          n.py = c.py - c.t1;
        end else if (c.shape == ssd_pkg::SH_STAR) begin
          n.px = vabs(c.px + c.t0);
          n.py = c.py + c.t1 - c.r;
        end
      end
      9: begin
        if (c.shape == ssd_pkg::SH_PENT) begin
          n.t0 = mulk(c.r, K_PZ);
        end else if (c.shape == ssd_pkg::SH_STAR) begin
          n.t0 = mulk(c.px, K_HX);
          n.t1 = mulk(c.py, K_NHY);
          n.t2 = mulk(c.py, K_BAX);
          n.t3 = mulk(c.px, K_NBAY);
        end
      end
      10: begin
        if (c.shape == ssd_pkg::SH_PENT) begin
          n.px = c.px - vclamp(c.px, -c.t0, c.t0);
          n.py = c.py - c.r;
        end else if (c.shape == ssd_pkg::SH_STAR) begin
          n.t0 = vclamp(c.t0 - c.t1, '0, c.r);
          n.t3 = c.t2 + c.t3;
        end
      end
      11: begin
        if (c.shape == ssd_pkg::SH_STAR) begin
          n.t1 = mulk(c.t0, K_BAX);
          n.t2 = mulk(c.t0, K_NBAY);
        end
      end
      12: begin
        if (c.shape == ssd_pkg::SH_STAR) begin
          n.px = c.px - c.t1;
          n.py = c.py + c.t2;
        end
      end
      default: n = c;
    endcase
    return n;
  endfunction

  function automatic ssd_pkg::lreq_t finish(ctx_t c);
    ssd_pkg::lreq_t q;
    q = '0;
    q.sg = ssd_pkg::SG_POS;
    case (c.shape)
      ssd_pkg::SH_SQUARE: begin
        q.la = vmax(c.px, '0);
        q.lb = vmax(c.py, '0);
        q.add = vmin(vmax(c.px, c.py), '0);
      end
      ssd_pkg::SH_CUBE: begin
        q.la = vmax(c.px, '0);
        q.lb = vmax(c.py, '0);
        q.lc = vmax(c.pz, '0);
        q.add = vmin(vmax(c.px, vmax(c.py, c.pz)), '0) - c.r;
      end
      ssd_pkg::SH_SPHERE: begin
        q.la = c.px;
        q.lb = c.py;
        q.lc = c.pz;
        q.add = -c.r;
      end
      ssd_pkg::SH_TRI: begin
        q.la = c.px;
        q.lb = c.py;
        q.sg = sgn_of(c.py, 1'b1);
      end
      ssd_pkg::SH_PENT: begin
        q.la = c.px;
        q.lb = c.py;
        q.sg = sgn_of(c.py, 1'b0);
      end
      ssd_pkg::SH_STAR: begin
        q.la = c.px;
        q.lb = c.py;
        q.sg = sgn_of(c.t3, 1'b0);
      end
      default: q.sg = ssd_pkg::SG_ZERO;
    endcase
    return q;
  endfunction

  ctx_t st  [NST];
  ctx_t nxt [NST];
  logic [NST-1:0] vld;

  always_comb begin
    ctx_t c0;
    val_t x, y, z, r;
    x = val_t'(point_x);
    y = val_t'(point_y);
    z = val_t'(point_z);
    r = val_t'(size);
    c0 = '0;
    c0.shape = shape;
    c0.r = r;
    case (shape)
      ssd_pkg::SH_SQUARE, ssd_pkg::SH_CUBE: begin
        c0.px = vabs(x) - r;
        c0.py = vabs(y) - r;
        c0.pz = vabs(z) - r;
      end
      ssd_pkg::SH_SPHERE: begin
        c0.px = x;
        c0.py = y;
        c0.pz = z;
      end
      ssd_pkg::SH_TRI: begin
        c0.px = vabs(x) - r;
        c0.py = y + mulk(r, K_SQRT3_HALF);
      end
      ssd_pkg::SH_PENT: begin
        c0.px = vabs(x);
        c0.py = -y;
      end
      ssd_pkg::SH_STAR: begin
        c0.px = vabs(x);
        c0.py = y + STAR_OFS;
      end
      default: c0.px = '0;
    endcase
    nxt[0] = c0;
    for (int g = 1; g < NST; g++) begin
      nxt[g] = step(g, st[g-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lreq_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_vld};
      lreq_vld <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NST; g++) begin
        st[g] <= nxt[g];
      end
      lreq <= finish(st[NST-1]);
    end
  end

endmodule

>>> hdl/ssd_len.sv
// Length front end: magnitudes, range scaling, squares and their sum.
// Feeds the root pipeline. Depends on ssd_pkg.
module ssd_len (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            lreq_vld,
  input  ssd_pkg::lreq_t  lreq,
  output logic            sq_vld,
  output ssd_pkg::sq_t    sq
);

  localparam int VW = ssd_pkg::VW;
  localparam int SHW = ssd_pkg::SHW;

  typedef struct packed {
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] c;
    logic [VW-1:0] m;
    ssd_pkg::val_t add;
    ssd_pkg::sgn_t sg;
  } mag_t;

  typedef struct packed {
    logic [30:0] a;
    logic [30:0] b;
    logic [30:0] c;
    logic [SHW-1:0] sh;
    ssd_pkg::val_t add;
    ssd_pkg::sgn_t sg;
  } nrm_t;

  typedef struct packed {
    logic [61:0] a;
    logic [61:0] b;
    logic [61:0] c;
    logic [SHW-1:0] sh;
    ssd_pkg::val_t add;
    ssd_pkg::sgn_t sg;
  } sqr_t;

  mag_t mg, mg_next;
  nrm_t nr, nr_next;
  sqr_t sr, sr_next;
  ssd_pkg::sq_t sq_next;
  logic [2:0] vld;

  always_comb begin
    logic [VW-1:0] mx;
    mg_next.a = lreq.la[VW-1] ? VW'(-lreq.la) : VW'(lreq.la);
    mg_next.b = lreq.lb[VW-1] ? VW'(-lreq.lb) : VW'(lreq.lb);
    mg_next.c = lreq.lc[VW-1] ? VW'(-lreq.lc) : VW'(lreq.lc);
    mx = (mg_next.b > mg_next.a) ? mg_next.b : mg_next.a;
    mg_next.m = (mg_next.c > mx) ? mg_next.c : mx;
    mg_next.add = lreq.add;
    mg_next.sg = lreq.sg;
  end

  always_comb begin
    logic [SHW-1:0] s;
    logic [VW-1:0] ta, tb, tc;
    s = '0;
    for (int i = 31; i < VW; i++) begin
      if (mg.m[i]) s = SHW'(i - 30);
    end
    ta = mg.a >> s;
    tb = mg.b >> s;
    tc = mg.c >> s;
    nr_next.a = ta[30:0];
    nr_next.b = tb[30:0];
    nr_next.c = tc[30:0];
    nr_next.sh = s;
    nr_next.add = mg.add;
    nr_next.sg = mg.sg;
  end

  always_comb begin
    sr_next.a = 62'(nr.a) * 62'(nr.a);
    sr_next.b = 62'(nr.b) * 62'(nr.b);
    sr_next.c = 62'(nr.c) * 62'(nr.c);
    sr_next.sh = nr.sh;
    sr_next.add = nr.add;
    sr_next.sg = nr.sg;
  end

  always_comb begin
    sq_next.n = 64'(sr.a) + 64'(sr.b) + 64'(sr.c);
    sq_next.root = '0;
    sq_next.sh = sr.sh;
    sq_next.add = sr.add;
    sq_next.sg = sr.sg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sq_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], lreq_vld};
      sq_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mg <= mg_next;
      nr <= nr_next;
      sr <= sr_next;
      sq <= sq_next;
    end
  end

endmodule

>>> hdl/ssd_sqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on ssd_pkg.
module ssd_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          sq_vld,
  input  ssd_pkg::sq_t  sq,
  output logic          rt_vld,
  output ssd_pkg::sq_t  rt
);

  localparam int NIT = 32;
  localparam int PER = 2;
  localparam int NST = NIT / PER;

  function automatic ssd_pkg::sq_t sq_iter(ssd_pkg::sq_t x, int i);
    ssd_pkg::sq_t y;
    logic [63:0] bit_v;
    logic [63:0] t;
    y = x;
    bit_v = 64'd1 << (62 - 2 * i);
    t = x.root + bit_v;
    if (x.n >= t) begin
      y.n = x.n - t;
      y.root = (x.root >> 1) + bit_v;
    end else begin
      y.root = x.root >> 1;
    end
    return y;
  endfunction

  ssd_pkg::sq_t st  [NST];
  ssd_pkg::sq_t nxt [NST];
  logic [NST-1:0] vld;

  always_comb begin
    ssd_pkg::sq_t cur;
    for (int g = 0; g < NST; g++) begin
      cur = (g == 0) ? sq : st[g-1];
      for (int k = 0; k < PER; k++) begin
        cur = sq_iter(cur, g * PER + k);
      end
      nxt[g] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], sq_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NST; g++) begin
        st[g] <= nxt[g];
      end
    end
  end

  assign rt = st[NST-1];
  assign rt_vld = vld[NST-1];

endmodule
